[hdl/source_text_tokenizer_top_macros.svh]
// Assertion helpers for the tokenizer, clocked on clk_i and held off during reset.
`ifndef SOURCE_TEXT_TOKENIZER_TOP_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define STT_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) else $error(msg);
`define STT_ASSERT_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) else $error(msg);
`else
`define STT_ASSERT_IMP(lbl, cond, prop, msg)
`define STT_ASSERT_NXT(lbl, cond, prop, msg)
`endif

`endif

[hdl/stt_pkg.sv]
`default_nettype none

package stt_pkg;

  localparam int unsigned LineBits   = 24;
  localparam int unsigned ColBits    = 16;
  localparam int unsigned OffsetBits = 32;
  localparam int unsigned LengthBits = 16;

  // Token kinds
  localparam logic [5:0] TK_INT    = 6'd0;
  localparam logic [5:0] TK_IDENT  = 6'd1;
  localparam logic [5:0] TK_FN     = 6'd2;
  localparam logic [5:0] TK_LPAR   = 6'd13;
  localparam logic [5:0] TK_RPAR   = 6'd14;
  localparam logic [5:0] TK_LBRACE = 6'd15;
  localparam logic [5:0] TK_RBRACE = 6'd16;
  localparam logic [5:0] TK_COMMA  = 6'd17;
  localparam logic [5:0] TK_COLON  = 6'd18;
  localparam logic [5:0] TK_SEMI   = 6'd19;
  localparam logic [5:0] TK_ARROW  = 6'd20;
  localparam logic [5:0] TK_PLUS   = 6'd21;
  localparam logic [5:0] TK_MINUS  = 6'd22;
  localparam logic [5:0] TK_STAR   = 6'd23;
  localparam logic [5:0] TK_SLASH  = 6'd24;
  localparam logic [5:0] TK_PCT    = 6'd25;
  localparam logic [5:0] TK_ASSIGN = 6'd26;
  localparam logic [5:0] TK_EQEQ   = 6'd27;
  localparam logic [5:0] TK_NE     = 6'd28;
  localparam logic [5:0] TK_LT     = 6'd29;
  localparam logic [5:0] TK_LE     = 6'd30;
  localparam logic [5:0] TK_GT     = 6'd31;
  localparam logic [5:0] TK_GE     = 6'd32;
  localparam logic [5:0] TK_ANDAND = 6'd33;
  localparam logic [5:0] TK_OROR   = 6'd34;
  localparam logic [5:0] TK_BANG   = 6'd35;
  localparam logic [5:0] TK_END    = 6'd36;
  localparam logic [5:0] TK_ERROR  = 6'd37;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_OVERFLOW = 3'd1;
  localparam logic [2:0] ERR_AMP      = 3'd2;
  localparam logic [2:0] ERR_BAR      = 3'd3;
  localparam logic [2:0] ERR_CHAR     = 3'd4;

  localparam logic [62:0] LitLimit = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [23:0] line_no;
    logic [15:0] col_no;
    logic [31:0] start_offset;
    logic [15:0] lexeme_length;
    logic [62:0] int_value;
    logic [2:0]  error_code;
    logic [7:0]  bad_char;
    logic        last;
  } tok_res_t;

  // Keyword lookup: prefix holds up to six bytes, first byte lowest
  function automatic logic [5:0] kw_kind(input logic [2:0] len, input logic [47:0] prefix);
    logic [5:0] k;
    k = TK_IDENT;
    case (len)
      3'd2: begin
        if (prefix == 48'h6E66) k = TK_FN;
        else if (prefix == 48'h6669) k = TK_FN + 6'd2;
      end
      3'd3: begin
        if (prefix == 48'h74656C) k = TK_FN + 6'd1;
        else if (prefix == 48'h746E69) k = TK_FN + 6'd7;
      end
      3'd4: begin
        if (prefix == 48'h65736C65) k = TK_FN + 6'd3;
        else if (prefix == 48'h6C6F6F62) k = TK_FN + 6'd8;
        else if (prefix == 48'h65757274) k = TK_FN + 6'd9;
      end
      3'd5: begin
        if (prefix == 48'h656C696877) k = TK_FN + 6'd4;
        else if (prefix == 48'h746E697270) k = TK_FN + 6'd6;
        else if (prefix == 48'h65736C6166) k = TK_FN + 6'd10;
      end
      3'd6: begin
        if (prefix == 48'h6E7275746572) k = TK_FN + 6'd5;
      end
      default: k = TK_IDENT;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[hdl/source_text_tokenizer_top.sv]
// A token is written into the result queue when the byte (or end marker) that ends it is accepted.
// Throughput: one input item per cycle while input ready is high; the result queue drains one token
//   per cycle while the receiver is ready, and an item may give two tokens.
// Input ready drops while fewer than two of the four result slots are free.
// Reset (rst_ni low, asynchronous) empties the queue and restarts at line 1, column 1, offset 0.
`default_nettype none

`include "source_text_tokenizer_top_macros.svh"

module source_text_tokenizer_top #(
  parameter int unsigned LINE_BITS   = stt_pkg::LineBits,
  parameter int unsigned COL_BITS    = stt_pkg::ColBits,
  parameter int unsigned OFFSET_BITS = stt_pkg::OffsetBits,
  parameter int unsigned LENGTH_BITS = stt_pkg::LengthBits
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output      logic         s_axis_tready_o,
  input  wire logic [7:0]   s_axis_tdata_i,   // [7:0] byte_req
  input  wire logic         s_axis_tuser_i,   // [0] kind
  output      logic         m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // [23:0] token line, [39:24] token column, [71:40] start_offset, [87:72] lexeme_length,
  // [150:88] int_value, [153:151] error_code, [161:154] bad_char, [167:162] zero
  output      logic [167:0] m_axis_tdata_o,
  output      logic [5:0]   m_axis_tuser_o,   // [5:0] token_kind
  output      logic         m_axis_tlast_o
);

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_NUM, MODE_IDENT, MODE_SLASH, MODE_COMMENT, MODE_MINUS,
    MODE_EQ, MODE_BANG, MODE_LT, MODE_GT, MODE_AMP, MODE_BAR
  } mode_e;

  mode_e                   mode_q, mode_d;
  logic [LINE_BITS-1:0]    cur_line_q, cur_line_d, tok_line_q, tok_line_d;
  logic [COL_BITS-1:0]     cur_col_q, cur_col_d, tok_col_q, tok_col_d;
  logic [OFFSET_BITS-1:0]  cur_off_q, cur_off_d, tok_off_q, tok_off_d;
  logic [LENGTH_BITS-1:0]  tok_len_q, tok_len_d;
  logic [62:0]             acc_q, acc_d;
  logic                    ovf_q, ovf_d;
  logic [47:0]             prefix_q, prefix_d;

  logic                    in_req, out_req;
  logic [7:0]              b;
  logic                    is_digit, is_alpha, is_ws;
  logic [67:0]             acc_next;

  stt_pkg::tok_res_t       fl_res, ib_res, end_res, r0, r1;
  logic                    fl_valid, ib_emit;
  mode_e                   ib_mode;
  logic [7:0]              op_second;
  logic [5:0]              op_pair;
  logic [1:0]              push_n;

  assign in_req = s_axis_tvalid_i && s_axis_tready_o;
  assign b      = s_axis_tdata_i;

  assign is_digit = (b >= 8'h30) && (b <= 8'h39);
  assign is_alpha = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A))
                    || (b == 8'h5F);
  assign is_ws    = (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);

  // acc * 10 + digit; overflow when the result passes 2^63-1
  assign acc_next = (68'(acc_q) << 3) + (68'(acc_q) << 1) + 68'(b - 8'h30);

  // Token that the pending mode gives when it is cut off
  always_comb begin
    fl_res = '0;
    fl_res.line_no       = 24'(tok_line_q);
    fl_res.col_no        = 16'(tok_col_q);
    fl_res.start_offset  = 32'(tok_off_q);
    fl_res.lexeme_length = 16'd1;
    fl_valid = 1'b1;
    op_second = 8'h3D;
    op_pair   = stt_pkg::TK_EQEQ;
    case (mode_q)
      MODE_NUM: begin
        fl_res.lexeme_length = 16'(tok_len_q);
        if (ovf_q) begin
          fl_res.token_kind = stt_pkg::TK_ERROR;
          fl_res.error_code = stt_pkg::ERR_OVERFLOW;
        end else begin
          fl_res.token_kind = stt_pkg::TK_INT;
          fl_res.int_value  = acc_q;
        end
      end
      MODE_IDENT: begin
        fl_res.lexeme_length = 16'(tok_len_q);
        fl_res.token_kind = (tok_len_q > LENGTH_BITS'(6)) ? stt_pkg::TK_IDENT
                            : stt_pkg::kw_kind(3'(tok_len_q), prefix_q);
      end
      MODE_SLASH: fl_res.token_kind = stt_pkg::TK_SLASH;
      MODE_MINUS: begin
        fl_res.token_kind = stt_pkg::TK_MINUS;
        op_second = 8'h3E;
        op_pair   = stt_pkg::TK_ARROW;
      end
      MODE_EQ: fl_res.token_kind = stt_pkg::TK_ASSIGN;
      MODE_BANG: begin
        fl_res.token_kind = stt_pkg::TK_BANG;
        op_pair = stt_pkg::TK_NE;
      end
      MODE_LT: begin
        fl_res.token_kind = stt_pkg::TK_LT;
        op_pair = stt_pkg::TK_LE;
      end
      MODE_GT: begin
        fl_res.token_kind = stt_pkg::TK_GT;
        op_pair = stt_pkg::TK_GE;
      end
      MODE_AMP: begin
        fl_res.token_kind = stt_pkg::TK_ERROR;
        fl_res.error_code = stt_pkg::ERR_AMP;
        fl_res.bad_char   = 8'h26;
        op_second = 8'h26;
        op_pair   = stt_pkg::TK_ANDAND;
      end
      MODE_BAR: begin
        fl_res.token_kind = stt_pkg::TK_ERROR;
        fl_res.error_code = stt_pkg::ERR_BAR;
        fl_res.bad_char   = 8'h7C;
        op_second = 8'h7C;
        op_pair   = stt_pkg::TK_OROR;
      end
      default: fl_valid = 1'b0;
    endcase
  end

  // Byte seen from the idle mode: new pending mode or a one-byte token
  always_comb begin
    ib_res = '0;
    ib_res.line_no       = 24'(cur_line_q);
    ib_res.col_no        = 16'(cur_col_q);
    ib_res.start_offset  = 32'(cur_off_q);
    ib_res.lexeme_length = 16'd1;
    ib_emit = 1'b0;
    ib_mode = MODE_IDLE;
    if (is_digit) begin
      ib_mode = MODE_NUM;
    end else if (is_alpha) begin
      ib_mode = MODE_IDENT;
    end else if (!is_ws) begin
      ib_emit = 1'b1;
      case (b)
        8'h2F: begin ib_mode = MODE_SLASH; ib_emit = 1'b0; end
        8'h2D: begin ib_mode = MODE_MINUS; ib_emit = 1'b0; end
        8'h3D: begin ib_mode = MODE_EQ;    ib_emit = 1'b0; end
        8'h21: begin ib_mode = MODE_BANG;  ib_emit = 1'b0; end
        8'h3C: begin ib_mode = MODE_LT;    ib_emit = 1'b0; end
        8'h3E: begin ib_mode = MODE_GT;    ib_emit = 1'b0; end
        8'h26: begin ib_mode = MODE_AMP;   ib_emit = 1'b0; end
        8'h7C: begin ib_mode = MODE_BAR;   ib_emit = 1'b0; end
        8'h28: ib_res.token_kind = stt_pkg::TK_LPAR;
        8'h29: ib_res.token_kind = stt_pkg::TK_RPAR;
        8'h7B: ib_res.token_kind = stt_pkg::TK_LBRACE;
        8'h7D: ib_res.token_kind = stt_pkg::TK_RBRACE;
        8'h2C: ib_res.token_kind = stt_pkg::TK_COMMA;
        8'h3A: ib_res.token_kind = stt_pkg::TK_COLON;
        8'h3B: ib_res.token_kind = stt_pkg::TK_SEMI;
        8'h2B: ib_res.token_kind = stt_pkg::TK_PLUS;
        8'h2A: ib_res.token_kind = stt_pkg::TK_STAR;
        8'h25: ib_res.token_kind = stt_pkg::TK_PCT;
        default: begin
          ib_res.token_kind = stt_pkg::TK_ERROR;
          ib_res.error_code = stt_pkg::ERR_CHAR;
          ib_res.bad_char   = b;
        end
      endcase
    end
  end

  // End-of-source token at the current position
  always_comb begin
    end_res = '0;
    end_res.token_kind   = stt_pkg::TK_END;
    end_res.line_no      = 24'(cur_line_q);
    end_res.col_no       = 16'(cur_col_q);
    end_res.start_offset = 32'(cur_off_q);
  end

  // Next state and results for one request
  always_comb begin
    logic step;
    logic general;
    step = 1'b0;
    general = 1'b0;
    mode_d = mode_q;
    cur_line_d = cur_line_q; cur_col_d = cur_col_q; cur_off_d = cur_off_q;
    tok_line_d = tok_line_q; tok_col_d = tok_col_q; tok_off_d = tok_off_q;
    tok_len_d = tok_len_q;
    acc_d = acc_q; ovf_d = ovf_q; prefix_d = prefix_q;
    r0 = '0;
    r1 = '0;
    push_n = 2'd0;

    if (in_req) begin
      if (s_axis_tuser_i) begin
        // end marker: pending token, end token, then back to reset state
        r0 = fl_valid ? fl_res : end_res;
        r1 = end_res;
        push_n = fl_valid ? 2'd2 : 2'd1;
        mode_d = MODE_IDLE;
        cur_line_d = LINE_BITS'(1); cur_col_d = COL_BITS'(1); cur_off_d = '0;
        tok_line_d = LINE_BITS'(1); tok_col_d = COL_BITS'(1); tok_off_d = '0;
        tok_len_d = '0; acc_d = '0; ovf_d = 1'b0; prefix_d = '0;
      end else begin
        step = 1'b1;
        if (mode_q == MODE_NUM && is_digit) begin
          tok_len_d = (&tok_len_q) ? tok_len_q : tok_len_q + LENGTH_BITS'(1);
          if (!ovf_q) begin
            if (acc_next > 68'(stt_pkg::LitLimit)) ovf_d = 1'b1;
            else acc_d = acc_next[62:0];
          end
        end else if (mode_q == MODE_IDENT && (is_alpha || is_digit)) begin
          tok_len_d = (&tok_len_q) ? tok_len_q : tok_len_q + LENGTH_BITS'(1);
          for (int i = 0; i < 6; i++) begin
            if (tok_len_q == LENGTH_BITS'(i)) prefix_d[8*i +: 8] = b;
          end
        end else if (mode_q == MODE_SLASH && b == 8'h2F) begin
          mode_d = MODE_COMMENT;
        end else if (mode_q == MODE_COMMENT && b != 8'h0A) begin
          mode_d = MODE_COMMENT;
        end else if (mode_q >= MODE_MINUS && b == op_second) begin
          r0 = fl_res;
          r0.token_kind    = op_pair;
          r0.lexeme_length = 16'd2;
          r0.error_code    = stt_pkg::ERR_NONE;
          r0.bad_char      = 8'h00;
          push_n = 2'd1;
          mode_d = MODE_IDLE;
        end else begin
          general = 1'b1;
        end

        if (general) begin
          if (fl_valid) begin
            r0 = fl_res;
            r1 = ib_res;
            push_n = ib_emit ? 2'd2 : 2'd1;
          end else begin
            r0 = ib_res;
            push_n = ib_emit ? 2'd1 : 2'd0;
          end
          mode_d = ib_mode;
          if (!is_ws) begin
            tok_line_d = cur_line_q;
            tok_col_d  = cur_col_q;
            tok_off_d  = cur_off_q;
            tok_len_d  = LENGTH_BITS'(1);
            if (is_digit) begin
              acc_d = 63'(b - 8'h30);
              ovf_d = 1'b0;
            end else if (is_alpha) begin
              prefix_d = 48'(b);
            end
          end
        end
      end

      // position of the next byte
      if (step) begin
        cur_off_d = (&cur_off_q) ? cur_off_q : cur_off_q + OFFSET_BITS'(1);
        if (b == 8'h0A) begin
          cur_line_d = (&cur_line_q) ? cur_line_q : cur_line_q + LINE_BITS'(1);
          cur_col_d  = COL_BITS'(1);
        end else begin
          cur_col_d = (&cur_col_q) ? cur_col_q : cur_col_q + COL_BITS'(1);
        end
      end

      if (push_n == 2'd2) r1.last = 1'b1;
      else r0.last = 1'b1;
    end
  end

  // Tokenizer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cur_line_q <= LINE_BITS'(1);
      cur_col_q  <= COL_BITS'(1);
      cur_off_q  <= '0;
      tok_line_q <= LINE_BITS'(1);
      tok_col_q  <= COL_BITS'(1);
      tok_off_q  <= '0;
      tok_len_q  <= '0;
      acc_q      <= '0;
      ovf_q      <= 1'b0;
      prefix_q   <= '0;
    end else begin
      mode_q <= mode_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      cur_off_q  <= cur_off_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      tok_off_q  <= tok_off_d;
      tok_len_q  <= tok_len_d;
      acc_q      <= acc_d;
      ovf_q      <= ovf_d;
      prefix_q   <= prefix_d;
    end
  end

  // Four-slot result queue
  stt_pkg::tok_res_t q_mem_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;
  stt_pkg::tok_res_t head;

  assign out_req = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = (count_q <= 3'd2);
  assign m_axis_tvalid_o = (count_q != 3'd0);
  assign head = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + push_n;
    rd_ptr_d = rd_ptr_q + 2'(out_req);
    count_d  = count_q + 3'(push_n) - 3'(out_req);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) q_mem_q[wr_ptr_q] <= r0;
    if (push_n == 2'd2) q_mem_q[wr_ptr_q + 2'd1] <= r1;
  end

  // Output mapping
  assign m_axis_tuser_o = head.token_kind;
  assign m_axis_tlast_o = head.last;
  assign m_axis_tdata_o = {6'd0, head.bad_char, head.error_code, head.int_value,
                           head.lexeme_length, head.start_offset, head.col_no,
                           head.line_no};

  `STT_ASSERT_IMP(a_no_queue_overrun, in_req, count_q <= 3'd2,
                  "request taken with queue too full")
  `STT_ASSERT_NXT(a_end_restarts, in_req && s_axis_tuser_i,
                  mode_q == MODE_IDLE && cur_off_q == '0, "end marker did not restart")
  `STT_ASSERT_NXT(a_last_drained, out_req && count_q == 3'd1 && !in_req,
                  !m_axis_tvalid_o, "queue not empty after last token")

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  // Lexer modes of the expected-token model
  typedef enum int {
    MD_IDLE, MD_NUM, MD_IDENT, MD_SLASH, MD_COMMENT, MD_MINUS, MD_EQ, MD_BANG,
    MD_LT, MD_GT, MD_AMP, MD_BAR
  } lex_mode_e;

  localparam int unsigned WatchLimit = 4000;
  localparam logic [63:0] LitMax = 64'h7FFF_FFFF_FFFF_FFFF;

  // Token model plus queue of expected tokens
  class token_scoreboard;
    stt_pkg::tok_res_t want_q[$];
    int          errs;
    lex_mode_e   mode;
    logic [23:0] cur_line, tok_line;
    logic [15:0] cur_col, tok_col, tok_len;
    logic [31:0] cur_off, tok_off;
    logic [63:0] acc;
    bit          ovf;
    logic [47:0] pfx;
    stt_pkg::tok_res_t res[2];
    int          nres;
    string       kw[11] = '{"fn", "let", "if", "else", "while", "return", "print", "int",
                            "bool", "true", "false"};

    function void clear();
      mode = MD_IDLE;
      cur_line = 1; cur_col = 1; cur_off = 0;
      tok_line = 1; tok_col = 1; tok_off = 0; tok_len = 0;
      acc = 0; ovf = 0; pfx = 0;
    endfunction

    function new();
      errs = 0;
      clear();
    endfunction

    function void advance(logic [7:0] b);
      if (cur_off != '1) cur_off++;
      if (b == 8'h0A) begin
        if (cur_line != '1) cur_line++;
        cur_col = 1;
      end else if (cur_col != '1) cur_col++;
    endfunction

    function void add_tok(logic [5:0] k, logic [15:0] len, logic [62:0] val,
                          logic [2:0] err, logic [7:0] bad);
      stt_pkg::tok_res_t t;
      t.token_kind = k; t.line_no = tok_line; t.col_no = tok_col;
      t.start_offset = tok_off; t.lexeme_length = len; t.int_value = val;
      t.error_code = err; t.bad_char = bad; t.last = 1'b0;
      res[nres] = t;
      nres++;
    endfunction

    function logic [5:0] word_kind();
      bit same;
      if (tok_len > 6) return stt_pkg::TK_IDENT;
      for (int k = 0; k < 11; k++) begin
        same = (kw[k].len() == tok_len);
        for (int i = 0; i < kw[k].len() && same; i++)
          if (kw[k][i] != pfx[8*i +: 8]) same = 0;
        if (same) return stt_pkg::TK_FN + 6'(k);
      end
      return stt_pkg::TK_IDENT;
    endfunction

    // Second byte that pairs with a pending operator start
    function logic [7:0] pair_byte(lex_mode_e m);
      case (m)
        MD_MINUS: return ">";
        MD_AMP:   return "&";
        MD_BAR:   return "|";
        default:  return "=";
      endcase
    endfunction

    function logic [5:0] pair_kind(lex_mode_e m);
      case (m)
        MD_MINUS: return stt_pkg::TK_ARROW;
        MD_EQ:    return stt_pkg::TK_EQEQ;
        MD_BANG:  return stt_pkg::TK_NE;
        MD_LT:    return stt_pkg::TK_LE;
        MD_GT:    return stt_pkg::TK_GE;
        MD_AMP:   return stt_pkg::TK_ANDAND;
        default:  return stt_pkg::TK_OROR;
      endcase
    endfunction

    function void flush();
      case (mode)
        MD_NUM:   if (ovf) add_tok(stt_pkg::TK_ERROR, tok_len, 0, stt_pkg::ERR_OVERFLOW, 0);
                  else add_tok(stt_pkg::TK_INT, tok_len, acc[62:0], stt_pkg::ERR_NONE, 0);
        MD_IDENT: add_tok(word_kind(), tok_len, 0, stt_pkg::ERR_NONE, 0);
        MD_SLASH: add_tok(stt_pkg::TK_SLASH, 1, 0, stt_pkg::ERR_NONE, 0);
        MD_MINUS: add_tok(stt_pkg::TK_MINUS, 1, 0, stt_pkg::ERR_NONE, 0);
        MD_EQ:    add_tok(stt_pkg::TK_ASSIGN, 1, 0, stt_pkg::ERR_NONE, 0);
        MD_BANG:  add_tok(stt_pkg::TK_BANG, 1, 0, stt_pkg::ERR_NONE, 0);
        MD_LT:    add_tok(stt_pkg::TK_LT, 1, 0, stt_pkg::ERR_NONE, 0);
        MD_GT:    add_tok(stt_pkg::TK_GT, 1, 0, stt_pkg::ERR_NONE, 0);
        MD_AMP:   add_tok(stt_pkg::TK_ERROR, 1, 0, stt_pkg::ERR_AMP, "&");
        MD_BAR:   add_tok(stt_pkg::TK_ERROR, 1, 0, stt_pkg::ERR_BAR, "|");
        default: ;
      endcase
      mode = MD_IDLE;
    endfunction

    function void fresh_byte(logic [7:0] b);
      bit is_alpha;
      is_alpha = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
      if (b == " " || b == 8'h09 || b == 8'h0D || b == 8'h0A) begin
        advance(b);
        return;
      end
      tok_line = cur_line; tok_col = cur_col; tok_off = cur_off; tok_len = 1;
      if (b >= "0" && b <= "9") begin
        mode = MD_NUM; acc = 64'(b - "0"); ovf = 0;
      end else if (is_alpha) begin
        mode = MD_IDENT; pfx = 48'(b);
      end else begin
        case (b)
          "/": mode = MD_SLASH;
          "-": mode = MD_MINUS;
          "=": mode = MD_EQ;
          "!": mode = MD_BANG;
          "<": mode = MD_LT;
          ">": mode = MD_GT;
          "&": mode = MD_AMP;
          "|": mode = MD_BAR;
          "(": add_tok(stt_pkg::TK_LPAR, 1, 0, stt_pkg::ERR_NONE, 0);
          ")": add_tok(stt_pkg::TK_RPAR, 1, 0, stt_pkg::ERR_NONE, 0);
          "{": add_tok(stt_pkg::TK_LBRACE, 1, 0, stt_pkg::ERR_NONE, 0);
          "}": add_tok(stt_pkg::TK_RBRACE, 1, 0, stt_pkg::ERR_NONE, 0);
          ",": add_tok(stt_pkg::TK_COMMA, 1, 0, stt_pkg::ERR_NONE, 0);
          ":": add_tok(stt_pkg::TK_COLON, 1, 0, stt_pkg::ERR_NONE, 0);
          ";": add_tok(stt_pkg::TK_SEMI, 1, 0, stt_pkg::ERR_NONE, 0);
          "+": add_tok(stt_pkg::TK_PLUS, 1, 0, stt_pkg::ERR_NONE, 0);
          "*": add_tok(stt_pkg::TK_STAR, 1, 0, stt_pkg::ERR_NONE, 0);
          "%": add_tok(stt_pkg::TK_PCT, 1, 0, stt_pkg::ERR_NONE, 0);
          default: add_tok(stt_pkg::TK_ERROR, 1, 0, stt_pkg::ERR_CHAR, b);
        endcase
      end
      advance(b);
    endfunction

    // Accepted request: work out the tokens it releases
    function void note_request(bit kind, logic [7:0] b);
      bit digit, word, taken;
      logic [63:0] d;
      nres = 0;
      taken = 0;
      digit = (b >= "0" && b <= "9");
      word = digit || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
      if (kind) begin
        flush();
        tok_line = cur_line; tok_col = cur_col; tok_off = cur_off;
        add_tok(stt_pkg::TK_END, 0, 0, stt_pkg::ERR_NONE, 0);
        clear();
      end else begin
        case (mode)
          MD_NUM: if (digit) begin
            d = 64'(b - "0");
            if (!ovf) begin
              if (acc > (LitMax - d) / 10) ovf = 1;
              else acc = acc * 10 + d;
            end
            taken = 1;
          end
          MD_IDENT: if (word) begin
            if (tok_len < 6) pfx[8*tok_len +: 8] = b;
            taken = 1;
          end
          MD_SLASH: if (b == "/") begin
            mode = MD_COMMENT; advance(b); return;
          end
          MD_COMMENT: begin
            if (b != 8'h0A) begin advance(b); return; end
            mode = MD_IDLE;
          end
          MD_IDLE: ;
          default: if (b == pair_byte(mode)) begin
            add_tok(pair_kind(mode), 2, 0, stt_pkg::ERR_NONE, 0);
            mode = MD_IDLE;
            advance(b);
            taken = 1;
            nres = 1;
          end
        endcase
        if (taken && nres == 0) begin
          if (tok_len != '1) tok_len++;
          advance(b);
        end else if (!taken) begin
          flush();
          fresh_byte(b);
        end
      end
      if (nres > 0) res[nres - 1].last = 1'b1;
      for (int i = 0; i < nres; i++) want_q = {want_q, res[i]};
    endfunction

    function void check_token(stt_pkg::tok_res_t got);
      stt_pkg::tok_res_t want;
      if (want_q.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected token %p", got);
        return;
      end
      want = want_q.pop_front();
      if (got !== want) begin
        errs++;
        if (errs <= 10) $display("token mismatch\n  exp %p\n  got %p", want, got);
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid_i = 0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i = 0;
  logic         s_axis_tuser_i = 0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 0;
  logic [167:0] m_axis_tdata_o;
  logic [5:0]   m_axis_tuser_o;
  logic         m_axis_tlast_o;

  token_scoreboard sb = new();
  int burst_left = 0;
  int idle_cycles = 0;
  int unsigned cyc = 0;
  int sent = 0;

  always #1 clk_i = ~clk_i;

  source_text_tokenizer_top uut (.*);

  // Receiver stall pattern: busy windows alternate with always-ready windows
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc[7]) m_axis_tready_i <= 1'b1;
    else if (cyc[6]) m_axis_tready_i <= ($urandom_range(0, 3) == 0);
    else m_axis_tready_i <= ($urandom_range(0, 2) != 0);
  end

  // Token monitor
  always @(posedge clk_i) begin
    stt_pkg::tok_res_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.token_kind = m_axis_tuser_o;
      got.line_no = m_axis_tdata_o[23:0];
      got.col_no = m_axis_tdata_o[39:24];
      got.start_offset = m_axis_tdata_o[71:40];
      got.lexeme_length = m_axis_tdata_o[87:72];
      got.int_value = m_axis_tdata_o[150:88];
      got.error_code = m_axis_tdata_o[153:151];
      got.bad_char = m_axis_tdata_o[161:154];
      got.last = m_axis_tlast_o;
      sb.check_token(got);
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // One request, sent in bursts with random gaps
  task automatic put(bit kind, logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    s_axis_tuser_i <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(kind, b);
    burst_left--;
    sent++;
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put(1'b0, s[i]);
  endtask

  // Random well-formed fragment, with some noise and end markers
  task automatic put_fragment();
    string ops[23] = '{"(", ")", "{", "}", ",", ":", ";", "->", "+", "-", "*", "/",
                       "%", "=", "==", "!=", "<", "<=", ">", ">=", "&&", "||", "!"};
    string kws[11] = '{"fn", "let", "if", "else", "while", "return", "print", "int",
                       "bool", "true", "false"};
    string wsp[4] = '{" ", "\n", "\t", "\r"};
    string chars = "abcxyzABCZ_09q";
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 20) put_text(kws[$urandom_range(0, 10)]);
    else if (r < 35) begin
      n = $urandom_range(1, 9);
      for (int i = 0; i < n; i++)
        put(1'b0, (i == 0) ? chars[$urandom_range(0, 10)] : chars[$urandom_range(0, 13)]);
    end else if (r < 52) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(18, 21) : $urandom_range(1, 5);
      for (int i = 0; i < n; i++) put(1'b0, 8'("0") + 8'($urandom_range(0, 9)));
    end else if (r < 74) put_text(ops[$urandom_range(0, 22)]);
    else if (r < 84) put_text(wsp[$urandom_range(0, 3)]);
    else if (r < 89) begin
      put_text("//");
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) put(1'b0, 8'($urandom_range(11, 255)));
      put(1'b0, 8'h0A);
    end else if (r < 97) put(1'b0, 8'($urandom_range(0, 255)));
    else put(1'b1, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1) == 0) put(1'b0, " ");
  endtask

  initial begin
    int start_cnt;
    bit drained;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: pairs, lone operators, odd bytes, overflowing literal, comment
    put_text("a->b&&c||d!=e 9223372036854775808//x\n");
    put(1'b0, 8'h00);
    put(1'b0, 8'hFF);
    put_text("& |7");
    put(1'b1, 8'hA5);

    start_cnt = sent;
    drained = 1'b0;
    while (sent - start_cnt < 520) begin
      put_fragment();
      // Hold off once until every expected token has drained
      if (!drained && sent - start_cnt > 250) begin
        drained = 1'b1;
        s_axis_tvalid_i <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
    end
    put(1'b1, 8'h00);
    s_axis_tvalid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errs == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/stt_pkg.sv
hdl/source_text_tokenizer_top.sv
bench/testbench.sv
